@@ hdl/quaternion_to_euler_core_assert.svh @@
// ---------------------------------------------------------------------------
// quaternion_to_euler_core assertion macros
// simulation-only checks, empty bodies for synthesis
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_CORE_ASSERT_SVH
`define QUATERNION_TO_EULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define Q2E_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q2e assertion failed");
// antecedent implies consequent in the next cycle
`define Q2E_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q2e assertion failed");
`else
`define Q2E_ASSERT_IMP(lbl, ante, cons)
`define Q2E_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ hdl/q2e_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_pkg
// shared constants, widths and the arctangent table
// ---------------------------------------------------------------------------
package q2e_pkg;

    localparam int FRACTION_BITS = 14;
    localparam int CORDIC_STAGES = 16;

    // operand width of sums and cordic inputs
    localparam int DW = 36;
    // root argument width and number of root stages
    localparam int SQ_W      = 34;
    localparam int SQ_STAGES = SQ_W / 2;
    // cordic datapath widths
    localparam int CW = 34;
    localparam int ZW = 33;
    // cordic latency: three preparation stages, iterations, result stage
    localparam int CORDIC_LAT = CORDIC_STAGES + 4;
    // whole pipeline: products, sums, roots, cordic, output register
    localparam int PIPE_LAT = 2 + SQ_STAGES + CORDIC_LAT + 1;

    localparam logic signed [DW-1:0] ONE = DW'(64'sd1 <<< (2 * FRACTION_BITS));
    localparam logic signed [ZW-1:0] QUARTER_TURN = 33'sd589824000;

    // atan(2^-i) in centidegrees times 2^16
    function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ZW-1:0] r;
        case (idx)
            5'd0:  r = 33'sd294912000;
            5'd1:  r = 33'sd174096719;
            5'd2:  r = 33'sd91987925;
            5'd3:  r = 33'sd46694507;
            5'd4:  r = 33'sd23437865;
            5'd5:  r = 33'sd11730358;
            5'd6:  r = 33'sd5866610;
            5'd7:  r = 33'sd2933483;
            5'd8:  r = 33'sd1466764;
            5'd9:  r = 33'sd733385;
            5'd10: r = 33'sd366693;
            5'd11: r = 33'sd183346;
            5'd12: r = 33'sd91673;
            5'd13: r = 33'sd45837;
            5'd14: r = 33'sd22918;
            5'd15: r = 33'sd11459;
            5'd16: r = 33'sd5730;
            5'd17: r = 33'sd2865;
            5'd18: r = 33'sd1432;
            5'd19: r = 33'sd716;
            5'd20: r = 33'sd358;
            5'd21: r = 33'sd179;
            5'd22: r = 33'sd90;
            5'd23: r = 33'sd45;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ hdl/quaternion_to_euler_core.sv @@
`timescale 1ns / 1ps
// an accepted request passes the product, sum, root, cordic and output registers
// throughput: one request per cycle unless stalled; all stages advance together
// a stall at the output freezes every stage, the cordic and root chains set depth
// reset clears only the valid bits; data registers keep their state
// ---------------------------------------------------------------------------
// quaternion_to_euler_core
// quaternion to roll, pitch and yaw in centidegrees
// ---------------------------------------------------------------------------
`include "quaternion_to_euler_core_assert.svh"
module quaternion_to_euler_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  qx,
    input  logic signed [15:0]  qy,
    input  logic signed [15:0]  qz,
    input  logic signed [15:0]  qw,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  roll,
    output logic signed [14:0]  pitch,
    output logic signed [15:0]  yaw
);

    localparam int DW  = q2e_pkg::DW;
    localparam int LAT = q2e_pkg::PIPE_LAT;
    localparam int SQN = q2e_pkg::SQ_STAGES;

    // pipeline advances whenever the output register is free or being drained
    logic en;
    logic [LAT-1:0] vld_reg, vld_next;

    assign en       = !vld_reg[LAT-1] || out_ready;
    assign in_ready = en;

    always_comb
    begin
        vld_next = {vld_reg[LAT-2:0], in_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= vld_next;
    end

    // stage 1: all the exact component products
    logic signed [31:0] wx_reg, yz_reg, xx_reg, yy_reg, zz_reg;
    logic signed [31:0] wz_reg, xy_reg, wy_reg, xz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            wy_reg <= qw * qy;
            xz_reg <= qx * qz;
        end
    end

    // stage 2: numerators, denominators and clamped root arguments
    logic signed [DW-1:0] rnum_reg, rden_reg, ynum_reg, yden_reg;
    logic [q2e_pkg::SQ_W-1:0] s1_reg, s2_reg;
    logic signed [DW-1:0] t2, s1, s2;

    always_comb
    begin
        t2 = (DW'(wy_reg) - DW'(xz_reg)) <<< 1;
        s1 = q2e_pkg::ONE + t2;
        s2 = q2e_pkg::ONE - t2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnum_reg <= (DW'(wx_reg) + DW'(yz_reg)) <<< 1;
            rden_reg <= q2e_pkg::ONE - ((DW'(xx_reg) + DW'(yy_reg)) <<< 1);
            ynum_reg <= (DW'(wz_reg) + DW'(xy_reg)) <<< 1;
            yden_reg <= q2e_pkg::ONE - ((DW'(yy_reg) + DW'(zz_reg)) <<< 1);
            // negative root argument saturates to zero
            s1_reg   <= s1[DW-1] ? '0 : s1[q2e_pkg::SQ_W-1:0];
            s2_reg   <= s2[DW-1] ? '0 : s2[q2e_pkg::SQ_W-1:0];
        end
    end

    // pitch roots
    logic [SQN-1:0] root1, root2;

    q2e_isqrt u_sqrt1 (.clk(clk), .en(en), .din(s1_reg), .root(root1));
    q2e_isqrt u_sqrt2 (.clk(clk), .en(en), .din(s2_reg), .root(root2));

    // roll and yaw operands wait alongside the root pipeline
    logic signed [DW-1:0] rnum_dly_reg [SQN];
    logic signed [DW-1:0] rden_dly_reg [SQN];
    logic signed [DW-1:0] ynum_dly_reg [SQN];
    logic signed [DW-1:0] yden_dly_reg [SQN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rnum_dly_reg[0] <= rnum_reg;
            rden_dly_reg[0] <= rden_reg;
            ynum_dly_reg[0] <= ynum_reg;
            yden_dly_reg[0] <= yden_reg;
            for (int i = 1; i < SQN; i++)
            begin
                rnum_dly_reg[i] <= rnum_dly_reg[i-1];
                rden_dly_reg[i] <= rden_dly_reg[i-1];
                ynum_dly_reg[i] <= ynum_dly_reg[i-1];
                yden_dly_reg[i] <= yden_dly_reg[i-1];
            end
        end
    end

    // three atan2 units in lockstep
    logic signed [q2e_pkg::ZW-1:0] roll_a, pitch_a, yaw_a;

    q2e_cordic u_cordic_roll
    (
        .clk(clk), .en(en),
        .y_in(rnum_dly_reg[SQN-1]), .x_in(rden_dly_reg[SQN-1]),
        .angle(roll_a)
    );

    q2e_cordic u_cordic_pitch
    (
        .clk(clk), .en(en),
        .y_in(DW'({1'b0, root1})), .x_in(DW'({1'b0, root2})),
        .angle(pitch_a)
    );

    q2e_cordic u_cordic_yaw
    (
        .clk(clk), .en(en),
        .y_in(ynum_dly_reg[SQN-1]), .x_in(yden_dly_reg[SQN-1]),
        .angle(yaw_a)
    );

    // output stage: round half up to centidegrees and saturate
    logic signed [33:0] roll_sum, yaw_sum;
    logic signed [34:0] pitch_sum;
    logic signed [17:0] roll_q, yaw_q;
    logic signed [18:0] pitch_q;
    logic signed [15:0] roll_next, yaw_next, roll_reg, yaw_reg;
    logic signed [14:0] pitch_next, pitch_reg;

    always_comb
    begin
        roll_sum  = 34'(roll_a) + 34'sd32768;
        yaw_sum   = 34'(yaw_a) + 34'sd32768;
        pitch_sum = (35'(pitch_a) <<< 1) - 35'(q2e_pkg::QUARTER_TURN) + 35'sd32768;
        roll_q    = 18'(roll_sum >>> 16);
        yaw_q     = 18'(yaw_sum >>> 16);
        pitch_q   = 19'(pitch_sum >>> 16);

        if (roll_q > 18'sd18000)
            roll_next = 16'sd18000;
        else if (roll_q < -18'sd18000)
            roll_next = -16'sd18000;
        else
            roll_next = 16'(roll_q);

        if (yaw_q > 18'sd18000)
            yaw_next = 16'sd18000;
        else if (yaw_q < -18'sd18000)
            yaw_next = -16'sd18000;
        else
            yaw_next = 16'(yaw_q);

        if (pitch_q > 19'sd9000)
            pitch_next = 15'sd9000;
        else if (pitch_q < -19'sd9000)
            pitch_next = -15'sd9000;
        else
            pitch_next = 15'(pitch_q);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_next;
            pitch_reg <= pitch_next;
            yaw_reg   <= yaw_next;
        end
    end

    assign out_valid = vld_reg[LAT-1];
    assign roll      = roll_reg;
    assign pitch     = pitch_reg;
    assign yaw       = yaw_reg;

    // a stall freezes every valid bit
    `Q2E_ASSERT_NXT(a_stall_holds, !en, $stable(vld_reg))
    // results stay within their angle ranges
    `Q2E_ASSERT_IMP(a_roll_range, out_valid, roll <= 16'sd18000 && roll >= -16'sd18000)
    `Q2E_ASSERT_IMP(a_pitch_range, out_valid, pitch <= 15'sd9000 && pitch >= -15'sd9000)
    `Q2E_ASSERT_IMP(a_yaw_range, out_valid, yaw <= 16'sd18000 && yaw >= -16'sd18000)

endmodule

@@ hdl/q2e_isqrt.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_isqrt
// pipelined floor square root, one result bit per stage
// ---------------------------------------------------------------------------
module q2e_isqrt
(
    input  logic                                 clk,
    input  logic                                 en,
    input  logic [q2e_pkg::SQ_W-1:0]             din,
    output logic [q2e_pkg::SQ_STAGES-1:0]        root
);

    logic [q2e_pkg::SQ_W-1:0] rem_reg [q2e_pkg::SQ_STAGES];
    logic [q2e_pkg::SQ_W-1:0] res_reg [q2e_pkg::SQ_STAGES];

    for (genvar k = 0; k < q2e_pkg::SQ_STAGES; k++) begin : g_stage
        logic [q2e_pkg::SQ_W-1:0] rem_in, res_in, trial, rem_next, res_next;
        localparam logic [q2e_pkg::SQ_W-1:0] BIT =
            q2e_pkg::SQ_W'(1) << (q2e_pkg::SQ_W - 2 - 2 * k);

        if (k == 0) begin : g_first
            assign rem_in = din;
            assign res_in = '0;
        end
        else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign res_in = res_reg[k-1];
        end

        always_comb
        begin
            trial = res_in + BIT;
            if (rem_in >= trial)
            begin
                rem_next = rem_in - trial;
                res_next = (res_in >> 1) + BIT;
            end
            else
            begin
                rem_next = rem_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                res_reg[k] <= res_next;
            end
        end
    end

    assign root = res_reg[q2e_pkg::SQ_STAGES-1][q2e_pkg::SQ_STAGES-1:0];

endmodule

@@ hdl/q2e_cordic.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// q2e_cordic
// pipelined vectoring cordic atan2, angle in centidegrees times 2^16
// ---------------------------------------------------------------------------
module q2e_cordic
(
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [q2e_pkg::DW-1:0]       y_in,
    input  logic signed [q2e_pkg::DW-1:0]       x_in,
    output logic signed [q2e_pkg::ZW-1:0]       angle
);

    localparam int N = q2e_pkg::CORDIC_STAGES;

    // preparation: quadrant fold
    logic                         p1_zero_reg, p1_neg_reg;
    logic [q2e_pkg::DW-1:0]       p1_cx_reg, p1_cy_reg;
    logic signed [q2e_pkg::ZW-1:0] p1_z_reg;
    logic [q2e_pkg::DW-1:0]       uy;

    always_comb
    begin
        uy = y_in[q2e_pkg::DW-1] ? q2e_pkg::DW'(-y_in) : q2e_pkg::DW'(y_in);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_zero_reg <= (x_in == '0) && (y_in == '0);
            p1_neg_reg  <= y_in[q2e_pkg::DW-1];
            if (x_in[q2e_pkg::DW-1])
            begin
                p1_cx_reg <= uy;
                p1_cy_reg <= q2e_pkg::DW'(-x_in);
                p1_z_reg  <= q2e_pkg::QUARTER_TURN;
            end
            else
            begin
                p1_cx_reg <= q2e_pkg::DW'(x_in);
                p1_cy_reg <= uy;
                p1_z_reg  <= '0;
            end
        end
    end

    // preparation: leading one of the larger operand
    logic                         p2_zero_reg, p2_neg_reg;
    logic [q2e_pkg::DW-1:0]       p2_cx_reg, p2_cy_reg;
    logic signed [q2e_pkg::ZW-1:0] p2_z_reg;
    logic [5:0]                   p2_pos_reg;
    logic [q2e_pkg::DW-1:0]       mag;
    logic [5:0]                   pos_next;

    always_comb
    begin
        mag = (p1_cx_reg > p1_cy_reg) ? p1_cx_reg : p1_cy_reg;
        pos_next = '0;
        for (int i = 0; i < q2e_pkg::DW; i++)
        begin
            if (mag[i])
                pos_next = 6'(i);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_zero_reg <= p1_zero_reg;
            p2_neg_reg  <= p1_neg_reg;
            p2_cx_reg   <= p1_cx_reg;
            p2_cy_reg   <= p1_cy_reg;
            p2_z_reg    <= p1_z_reg;
            p2_pos_reg  <= pos_next;
        end
    end

    // preparation: normalise larger operand into [2^29, 2^30)
    logic signed [q2e_pkg::CW-1:0] it_cx_reg [N+1];
    logic signed [q2e_pkg::CW-1:0] it_cy_reg [N+1];
    logic signed [q2e_pkg::ZW-1:0] it_z_reg  [N+1];
    logic                          it_zero_reg [N+1];
    logic                          it_neg_reg  [N+1];
    logic [q2e_pkg::DW-1:0]        nx, ny;

    always_comb
    begin
        if (p2_pos_reg >= 6'd30)
        begin
            nx = p2_cx_reg >> (p2_pos_reg - 6'd29);
            ny = p2_cy_reg >> (p2_pos_reg - 6'd29);
        end
        else
        begin
            nx = p2_cx_reg << (6'd29 - p2_pos_reg);
            ny = p2_cy_reg << (6'd29 - p2_pos_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            it_cx_reg[0]   <= q2e_pkg::CW'({1'b0, nx[29:0]});
            it_cy_reg[0]   <= q2e_pkg::CW'({1'b0, ny[29:0]});
            it_z_reg[0]    <= p2_z_reg;
            it_zero_reg[0] <= p2_zero_reg;
            it_neg_reg[0]  <= p2_neg_reg;
        end
    end

    // micro-rotations, one per stage
    for (genvar k = 0; k < N; k++) begin : g_iter
        logic signed [q2e_pkg::CW-1:0] dx, dy;
        assign dx = it_cy_reg[k] >>> k;
        assign dy = it_cx_reg[k] >>> k;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (it_cy_reg[k] > 0)
                begin
                    it_cx_reg[k+1] <= it_cx_reg[k] + dx;
                    it_cy_reg[k+1] <= it_cy_reg[k] - dy;
                    it_z_reg[k+1]  <= it_z_reg[k] + q2e_pkg::atan_lut(5'(k));
                end
                else
                begin
                    it_cx_reg[k+1] <= it_cx_reg[k] - dx;
                    it_cy_reg[k+1] <= it_cy_reg[k] + dy;
                    it_z_reg[k+1]  <= it_z_reg[k] - q2e_pkg::atan_lut(5'(k));
                end
                it_zero_reg[k+1] <= it_zero_reg[k];
                it_neg_reg[k+1]  <= it_neg_reg[k];
            end
        end
    end

    // sign restore, atan2(0,0) forced to zero
    logic signed [q2e_pkg::ZW-1:0] angle_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (it_zero_reg[N])
                angle_reg <= '0;
            else if (it_neg_reg[N])
                angle_reg <= -it_z_reg[N];
            else
                angle_reg <= it_z_reg[N];
        end
    end

    assign angle = angle_reg;

endmodule

@@ verif/quaternion_to_euler_core_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_to_euler_core_checker
// watches both channels, predicts roll, pitch and yaw for every accepted
// request and compares each result in order with the oldest prediction
// ---------------------------------------------------------------------------
module quaternion_to_euler_core_checker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic signed [15:0]  qx,
    input  logic signed [15:0]  qy,
    input  logic signed [15:0]  qz,
    input  logic signed [15:0]  qw,
    input  logic                out_valid,
    input  logic                out_ready,
    input  logic signed [15:0]  roll,
    input  logic signed [14:0]  pitch,
    input  logic signed [15:0]  yaw,
    output int                  fail_count,
    output int                  pending_angles,
    output int                  results_seen
);

    typedef struct packed {
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] yaw;
    } euler_t;

    localparam longint QUARTER_Q16 = 64'sd589824000;

    euler_t angle_queue[$];

    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic longint int_root(input longint arg);
        longint unsigned v, res, b;
        v = arg;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    // vectoring arctangent in centidegrees times 2^16
    function automatic longint vec_angle(input longint ay, input longint ax);
        logic   neg;
        longint cx, cy, m, acc, dx, dy;
        acc = 0;
        if (ax == 0 && ay == 0)
            return 0;
        neg = ay < 0;
        if (ax < 0)
        begin
            cx = neg ? -ay : ay;
            cy = -ax;
            acc = QUARTER_Q16;
        end
        else
        begin
            cx = ax;
            cy = neg ? -ay : ay;
        end
        m = (cx > cy) ? cx : cy;
        while (m >= (64'sd1 <<< 30))
        begin
            cx = cx >>> 1;
            cy = cy >>> 1;
            m = m >>> 1;
        end
        while (m < (64'sd1 <<< 29))
        begin
            cx = cx <<< 1;
            cy = cy <<< 1;
            m = m <<< 1;
        end
        for (int i = 0; i < q2e_pkg::CORDIC_STAGES && i < 24; i++)
        begin
            dx = asr(cy, i);
            dy = asr(cx, i);
            if (cy > 0)
            begin
                cx = cx + dx;
                cy = cy - dy;
                acc = acc + longint'(q2e_pkg::atan_lut(5'(i)));
            end
            else
            begin
                cx = cx - dx;
                cy = cy + dy;
                acc = acc - longint'(q2e_pkg::atan_lut(5'(i)));
            end
        end
        return neg ? -acc : acc;
    endfunction

    function automatic longint centideg(input longint a, input longint lim);
        longint r;
        r = asr(a + 32768, 16);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic euler_t predict_angles(input longint x, input longint y,
                                              input longint z, input longint w);
        euler_t e;
        longint unity, t, s1, s2, a;
        unity = 64'sd1 <<< (2 * q2e_pkg::FRACTION_BITS);
        e.roll = 16'(centideg(vec_angle(2 * (w * x + y * z),
                                        unity - 2 * (x * x + y * y)), 18000));
        t = w * y - x * z;
        s1 = unity + 2 * t;
        s2 = unity - 2 * t;
        if (s1 < 0)
            s1 = 0;
        if (s2 < 0)
            s2 = 0;
        a = vec_angle(int_root(s1), int_root(s2));
        e.pitch = 15'(centideg(2 * a - QUARTER_Q16, 9000));
        e.yaw = 16'(centideg(vec_angle(2 * (w * z + x * y),
                                       unity - 2 * (y * y + z * z)), 18000));
        return e;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        euler_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            results_seen <= 0;
            pending_angles <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (angle_queue.size() == 0)
                begin
                    $error("result with no request pending");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = angle_queue.pop_front();
                    if (roll !== e.roll || pitch !== e.pitch || yaw !== e.yaw)
                        fail_count <= fail_count + 1;
                    if (roll !== e.roll)
                        $error("roll expected %0d actual %0d", e.roll, roll);
                    if (pitch !== e.pitch)
                        $error("pitch expected %0d actual %0d", e.pitch, pitch);
                    if (yaw !== e.yaw)
                        $error("yaw expected %0d actual %0d", e.yaw, yaw);
                end
            end
            if (in_valid && in_ready)
                angle_queue.push_back(predict_angles(qx, qy, qz, qw));
            // requests still waiting for their result
            pending_angles <= angle_queue.size();
        end
    end

endmodule

@@ verif/quaternion_to_euler_core_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// quaternion_to_euler_core_test
// directed corner quaternions then random unit and raw quaternions through
// the converter, with random stalls on both channels; a checker compares
// ---------------------------------------------------------------------------
module quaternion_to_euler_core_test;

    localparam int RANDOM_REQUESTS = 1830;
    // cycles without any handshake before giving up
    localparam int STALL_LIMIT = 2000;
    localparam int TAIL_CYCLES = 60;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    int                 fail_count;
    int                 pending_angles;
    int                 results_seen;
    int                 sent_count;
    int                 idle_cycles;
    logic               quiet_tail;

    quaternion_to_euler_core u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .qx        (qx),
        .qy        (qy),
        .qz        (qz),
        .qw        (qw),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .roll      (roll),
        .pitch     (pitch),
        .yaw       (yaw)
    );

    quaternion_to_euler_core_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .qx             (qx),
        .qy             (qy),
        .qz             (qz),
        .qw             (qw),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .roll           (roll),
        .pitch          (pitch),
        .yaw            (yaw),
        .fail_count     (fail_count),
        .pending_angles (pending_angles),
        .results_seen   (results_seen)
    );

    initial
        clk = 1'b0;
    always
        #5 clk = ~clk;

    // receiver: random stall bursts, none in the quiet tail
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5) - 1)
                    @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("quaternion_to_euler_core_test failed");
            $finish;
        end
    end

    // one request, held until accepted, with an optional idle burst first
    task automatic send_quat(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z, input logic [15:0] w);
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
        in_valid <= 1'b1;
        qx <= x;
        qy <= y;
        qz <= z;
        qw <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent_count++;
    endtask

    // roughly unit quaternion with random direction
    task automatic send_unit_quat();
        real a, b, c, d, n;
        a = real'($urandom_range(0, 65534)) - 32767.0;
        b = real'($urandom_range(0, 65534)) - 32767.0;
        c = real'($urandom_range(0, 65534)) - 32767.0;
        d = real'($urandom_range(0, 65534)) - 32767.0;
        n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
        send_quat(16'($rtoi(a / n * 16384.0)), 16'($rtoi(b / n * 16384.0)),
                  16'($rtoi(c / n * 16384.0)), 16'($rtoi(d / n * 16384.0)));
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        qx = '0;
        qy = '0;
        qz = '0;
        qw = '0;
        quiet_tail = 1'b0;
        sent_count = 0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, axis turns, gimbal lock, zero, extremes
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
        send_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
        send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        send_quat(16'sd0, 16'sd0, 16'sd11585, -16'sd11585);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384);
        send_quat(-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(16'sd0, 16'sd16384, 16'sd16384, 16'sd0);
        send_quat(16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, -16'sd1, 16'sd0);
        send_quat(16'sd16384, 16'sd0, 16'sd0, -16'sd1);

        // let every result drain before going on
        in_valid <= 1'b0;
        while (pending_angles != 0)
            @(posedge clk);

        for (k = 0; k < RANDOM_REQUESTS; k++)
        begin
            if (k == RANDOM_REQUESTS - 200)
                quiet_tail = 1'b1;
            if (k == RANDOM_REQUESTS / 2)
            begin
                in_valid <= 1'b0;
                while (pending_angles != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 9))
                0, 1:
                    send_quat(16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom));
                2:
                    send_quat(16'($urandom_range(0, 32768) - 16384),
                              16'($urandom_range(0, 32768) - 16384),
                              16'($urandom_range(0, 32768) - 16384),
                              16'($urandom_range(0, 32768) - 16384));
                default:
                    send_unit_quat();
            endcase
        end
        in_valid <= 1'b0;

        while (pending_angles != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        $display("sent %0d quaternions (corners, unit and raw words), checked %0d results",
                 sent_count, results_seen);
        if (fail_count == 0)
            $display("quaternion_to_euler_core_test passed");
        else
            $display("quaternion_to_euler_core_test failed");
        $finish;
    end

endmodule
